// ===== rtl/core/porc_pkg.sv =====
`timescale 1ns / 1ps

package porc_pkg;

  // table geometry
  localparam int unsigned BUCKET_BITS = 8;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int unsigned WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [31:0] HASH_MULT = 32'h9e37_0001;

  localparam logic [7:0] REFS_MAX = 8'd255;

  // request kinds
  localparam logic [1:0] KIND_MARK   = 2'd0;
  localparam logic [1:0] KIND_UNMARK = 2'd1;
  localparam logic [1:0] KIND_FETCH  = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_IGNORED = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_MISS    = 2'd3;

  // marker change codes
  localparam logic [1:0] MARKER_NONE    = 2'd0;
  localparam logic [1:0] MARKER_SET     = 2'd1;
  localparam logic [1:0] MARKER_CLEARED = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [15:0] port;
    logic [15:0] owner;
    logic        ambiguous;
    logic [7:0]  refs;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] port;
    logic [15:0] owner;
    logic        owner_marked;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        owner_valid;
    logic [15:0] found_owner;
    logic [1:0]  marker_change;
    logic [7:0]  ref_count;
  } res_t;

  // bucket index: top bits of the low word of port times the multiplier
  function automatic logic [BUCKET_BITS-1:0] bucket_of(logic [15:0] port);
    logic [31:0] h;
    h = 32'({16'b0, port} * HASH_MULT);
    return h[31 -: BUCKET_BITS];
  endfunction

endpackage

// ===== rtl/core/port_owner_refcount_table_unit.sv =====
`timescale 1ns / 1ps
// a request is captured along with its bucket row read, then its result is written to
//   the result register; this waits while the result register holds a stalled output
// a new request is taken only after the previous one is written back (bucket row
//   read, then write-back through the single row memory)
// reset: enable goes to 1 and every bucket row is marked empty at once by a
//   per-row flag; there is no clearing pass, requests are taken straight away

module port_owner_refcount_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  in_kind_i,
  input  logic [15:0] in_port_i,
  input  logic [15:0] in_owner_i,
  input  logic        in_owner_marked_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_status_o,
  output logic        out_owner_valid_o,
  output logic [15:0] out_found_owner_o,
  output logic [1:0]  out_marker_change_o,
  output logic [7:0]  out_ref_count_o
);

  localparam int unsigned ROW_W = $bits(porc_pkg::row_t);

  porc_pkg::state_e                  state_q, state_d;
  logic                              enable_q;
  porc_pkg::req_t                    req_q;
  logic [porc_pkg::BUCKET_BITS-1:0]  bkt_q;
  logic [porc_pkg::NUM_BUCKETS-1:0]  row_init_q;
  logic                              out_valid_q;
  porc_pkg::res_t                    res_q;

  logic                              in_fire;
  logic                              exec_go;
  logic [porc_pkg::BUCKET_BITS-1:0]  in_bkt;
  logic [ROW_W-1:0]                  rd_row;
  porc_pkg::row_t                    row_view;
  porc_pkg::row_t                    row_new;
  logic                              row_we;
  porc_pkg::res_t                    res_new;

  assign in_fire = in_valid_i && in_ready_o;
  assign in_bkt  = porc_pkg::bucket_of(in_port_i);

  // enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= porc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and handshake
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    exec_go    = 1'b0;
    unique case (state_q)
      porc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = porc_pkg::ST_EXEC;
        end
      end
      porc_pkg::ST_EXEC: begin
        // wait for the result register to be free
        if (!out_valid_q || out_ready_i) begin
          exec_go = 1'b1;
          state_d = porc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = porc_pkg::ST_IDLE;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q.kind         <= in_kind_i;
      req_q.port         <= in_port_i;
      req_q.owner        <= in_owner_i;
      req_q.owner_marked <= in_owner_marked_i;
      bkt_q              <= in_bkt;
    end
  end

  // bucket row memory
  porc_ram #(
    .DATA_W (ROW_W),
    .ADDR_W (porc_pkg::BUCKET_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (in_fire),
    .raddr_i (in_bkt),
    .rdata_o (rd_row),
    .we_i    (exec_go && row_we),
    .waddr_i (bkt_q),
    .wdata_i (row_new)
  );

  // rows never written read as empty
  always_comb begin
    row_view = porc_pkg::row_t'(rd_row);
    for (int w = 0; w < porc_pkg::WAYS; w++) begin
      row_view[w].valid = row_view[w].valid && row_init_q[bkt_q];
    end
  end

  porc_bucket_logic u_logic (
    .enable_i (enable_q),
    .req_i    (req_q),
    .row_i    (row_view),
    .row_o    (row_new),
    .we_o     (row_we),
    .res_o    (res_new)
  );

  // per-row written flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_init_q <= '0;
    end else if (exec_go && row_we) begin
      row_init_q[bkt_q] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      res_q <= res_new;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = res_q.status;
  assign out_owner_valid_o   = res_q.owner_valid;
  assign out_found_owner_o   = res_q.found_owner;
  assign out_marker_change_o = res_q.marker_change;
  assign out_ref_count_o     = res_q.ref_count;

endmodule

// ===== rtl/core/porc_ram.sv =====
`timescale 1ns / 1ps

module porc_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/core/porc_bucket_logic.sv =====
`timescale 1ns / 1ps

module porc_bucket_logic (
  input  logic            enable_i,
  input  porc_pkg::req_t  req_i,
  input  porc_pkg::row_t  row_i,
  output porc_pkg::row_t  row_o,
  output logic            we_o,
  output porc_pkg::res_t  res_o
);

  logic                      hit_found;
  logic [porc_pkg::WAY_W-1:0] hit_idx;
  logic                      free_found;
  logic [porc_pkg::WAY_W-1:0] free_idx;
  porc_pkg::entry_t          hit_entry;

  // way search, lowest way first
  always_comb begin
    hit_found  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int w = 0; w < porc_pkg::WAYS; w++) begin
      if (!hit_found && row_i[w].valid && row_i[w].port == req_i.port) begin
        hit_found = 1'b1;
        hit_idx   = porc_pkg::WAY_W'(w);
      end
      if (!free_found && !row_i[w].valid) begin
        free_found = 1'b1;
        free_idx   = porc_pkg::WAY_W'(w);
      end
    end
  end

  assign hit_entry = row_i[hit_idx];

  // update of the bucket row and the result
  always_comb begin
    row_o = row_i;
    we_o  = 1'b0;
    res_o = '0;
    res_o.status = porc_pkg::STATUS_IGNORED;
    unique case (req_i.kind)
      porc_pkg::KIND_MARK: begin
        if (enable_i) begin
          if (hit_found) begin
            if (hit_entry.refs != porc_pkg::REFS_MAX) begin
              row_o[hit_idx].refs = hit_entry.refs + 8'd1;
            end
            row_o[hit_idx].owner     = '0;
            row_o[hit_idx].ambiguous = 1'b1;
            res_o.status    = porc_pkg::STATUS_DONE;
            res_o.ref_count = row_o[hit_idx].refs;
            we_o = 1'b1;
          end else if (free_found) begin
            row_o[free_idx].valid     = 1'b1;
            row_o[free_idx].port      = req_i.port;
            row_o[free_idx].owner     = req_i.owner;
            row_o[free_idx].ambiguous = 1'b0;
            row_o[free_idx].refs      = 8'd1;
            res_o.status        = porc_pkg::STATUS_DONE;
            res_o.marker_change = porc_pkg::MARKER_SET;
            res_o.ref_count     = 8'd1;
            we_o = 1'b1;
          end else begin
            res_o.status = porc_pkg::STATUS_FULL;
          end
        end
      end
      porc_pkg::KIND_UNMARK: begin
        if (req_i.owner_marked) begin
          if (!hit_found) begin
            res_o.status = porc_pkg::STATUS_MISS;
          end else begin
            res_o.status = porc_pkg::STATUS_DONE;
            we_o = 1'b1;
            if (hit_entry.refs > 8'd1) begin
              row_o[hit_idx].refs = hit_entry.refs - 8'd1;
              res_o.ref_count     = hit_entry.refs - 8'd1;
            end else begin
              // last reference gone, entry freed
              row_o[hit_idx].valid = 1'b0;
              row_o[hit_idx].refs  = '0;
              res_o.marker_change  = porc_pkg::MARKER_CLEARED;
            end
          end
        end
      end
      porc_pkg::KIND_FETCH: begin
        if (!hit_found) begin
          res_o.status = porc_pkg::STATUS_MISS;
        end else begin
          res_o.status    = porc_pkg::STATUS_DONE;
          res_o.ref_count = hit_entry.refs;
          if (!hit_entry.ambiguous) begin
            res_o.owner_valid = 1'b1;
            res_o.found_owner = hit_entry.owner;
          end
        end
      end
      default: begin
        res_o.status = porc_pkg::STATUS_IGNORED;
      end
    endcase
  end

endmodule
